/* sv/nie_pkg.sv */
`timescale 1ns / 1ps

package nie_pkg;

  localparam int MAX_POINTS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 1'b1;

  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q_ONE     = 64'd1 << FRAC_BITS;

  typedef enum logic [1:0] {
    METH_AUTO = 2'd0,
    METH_FWD  = 2'd1,
    METH_BWD  = 2'd2,
    METH_DIV  = 2'd3
  } method_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_DIV = 2'd1,
    STAT_SAT      = 2'd2
  } status_e;

  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } sat_val_t;

  typedef struct packed {
    logic [CNT_W-1:0]   n;
    logic signed [31:0] x0;
    logic signed [31:0] xl;
    logic signed [32:0] h;
    logic               uneven;
  } job_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [31:0]      x;
    logic [31:0]      y;
  } load_wr_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [63:0]      data;
  } tbl_wr_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [63:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic        qmode;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [63:0] q;
  } div_rsp_t;

  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic sat_val_t from_mag(input logic [63:0] m, input logic neg,
                                        input logic over);
    sat_val_t r;
    if (neg) begin
      if (over || (m > INT64_MIN)) begin
        r.sat = 1'b1;
        r.val = INT64_MIN;
      end else begin
        r.sat = 1'b0;
        r.val = 64'd0 - m;
      end
    end else begin
      if (over || m[63]) begin
        r.sat = 1'b1;
        r.val = INT64_MAX;
      end else begin
        r.sat = 1'b0;
        r.val = m;
      end
    end
    return r;
  endfunction

  function automatic sat_val_t sadd(input logic [63:0] a, input logic [63:0] b);
    sat_val_t   r;
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r.sat = 1'b1;
      r.val = s[64] ? INT64_MIN : INT64_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[63:0];
    end
    return r;
  endfunction

  function automatic sat_val_t ssub(input logic [63:0] a, input logic [63:0] b);
    sat_val_t   r;
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      r.sat = 1'b1;
      r.val = s[64] ? INT64_MIN : INT64_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[63:0];
    end
    return r;
  endfunction

endpackage

/* sv/nie_ram.sv */
`timescale 1ns / 1ps

module nie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/nie_mul.sv */
`timescale 1ns / 1ps

module nie_mul import nie_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam logic [2:0] LAST_PROD = 3'd3;
  localparam logic [2:0] LAST_ACC  = 3'd4;
  localparam logic [2:0] FINISH    = 3'd5;

  logic         busy_q;
  logic [2:0]   cnt_q;
  logic [63:0]  ma_q, mb_q;
  logic         neg_q;
  logic [63:0]  prod_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic         done_q;
  logic         sat_q;
  logic [63:0]  p_q;
  logic [31:0]  ah, bh;
  sat_val_t     fin;

  assign ah  = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign bh  = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign fin = from_mag(acc_q[FRAC_BITS+63:FRAC_BITS], neg_q, |acc_q[127:FRAC_BITS+64]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == FINISH) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ma_q  <= mag64(req_i.a);
      mb_q  <= mag64(req_i.b);
      neg_q <= req_i.a[63] ^ req_i.b[63];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q <= LAST_PROD) begin
        prod_q <= {32'd0, ah} * {32'd0, bh};
        sh_q   <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
      if ((cnt_q != 3'd0) && (cnt_q <= LAST_ACC)) begin
        acc_q <= acc_q + ({64'd0, prod_q} << {sh_q, 5'd0});
      end
      if (cnt_q == FINISH) begin
        sat_q <= fin.sat;
        p_q   <= fin.val;
      end
    end
  end

  assign rsp_o = {done_q, sat_q, p_q};

endmodule

/* sv/nie_div.sv */
`timescale 1ns / 1ps

module nie_div import nie_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int DIV_STEPS = 64;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  logic              busy_q;
  logic [STEP_W-1:0] cnt_q;
  logic [64:0]       r_q;
  logic [63:0]       lo_q, q_q, d_q;
  logic              neg_q;
  logic              done_q;
  logic              sat_q;
  logic [63:0]       quo_q;

  logic [63:0] ma, dm, hi_s, lo_s;
  logic        neg_s, early;
  logic [64:0] r2;
  logic        ge;
  logic [63:0] q_next;
  sat_val_t    ovf, fin;

  assign ma     = mag64(req_i.num);
  assign dm     = mag64(req_i.den);
  assign neg_s  = req_i.num[63] ^ req_i.den[63];
  assign hi_s   = req_i.qmode ? (ma >> (64 - FRAC_BITS)) : 64'd0;
  assign lo_s   = req_i.qmode ? (ma << FRAC_BITS) : ma;
  assign early  = req_i.qmode && (hi_s >= dm);
  assign ovf    = from_mag(64'd0, neg_s, 1'b1);
  assign r2     = {r_q[63:0], lo_q[63]};
  assign ge     = r2 >= {1'b0, d_q};
  assign q_next = {q_q[62:0], ge};
  assign fin    = from_mag(q_next, neg_q, 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (early) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= STEP_W'(DIV_STEPS - 1);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q   <= {1'b0, hi_s};
      lo_q  <= lo_s;
      q_q   <= '0;
      d_q   <= dm;
      neg_q <= neg_s;
      if (early) begin
        sat_q <= ovf.sat;
        quo_q <= ovf.val;
      end
    end else if (busy_q) begin
      r_q  <= ge ? (r2 - {1'b0, d_q}) : r2;
      lo_q <= {lo_q[62:0], 1'b0};
      q_q  <= q_next;
      if (cnt_q == '0) begin
        sat_q <= fin.sat;
        quo_q <= fin.val;
      end
    end
  end

  assign rsp_o = {done_q, sat_q, quo_q};

endmodule

/* sv/nie_front.sv */
`timescale 1ns / 1ps

module nie_front import nie_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] in_x_i,
  input  logic [31:0] in_y_i,
  input  logic        in_last_i,
  input  logic        fifo_full_i,
  input  logic        done_i,
  output logic        job_push_o,
  output job_t        job_o,
  output load_wr_t    ld_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             uneven_q, uneven_d;
  logic             pending_q, pending_d;
  logic [31:0]      x0_q, x0_d, xprev_q, xprev_d;
  logic [32:0]      h_q, h_d;
  logic             accept, store;
  logic [32:0]      diff;

  assign in_ready_o = !pending_q && !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign store      = accept && (cnt_q < CNT_W'(MAX_POINTS));
  assign diff       = {in_x_i[31], in_x_i} - {xprev_q[31], xprev_q};

  always_comb begin
    cnt_d      = cnt_q;
    uneven_d   = uneven_q;
    pending_d  = pending_q;
    x0_d       = x0_q;
    xprev_d    = xprev_q;
    h_d        = h_q;
    job_push_o = 1'b0;
    if (store) begin
      if (cnt_q == CNT_W'(0)) begin
        x0_d = in_x_i;
      end
      if (cnt_q == CNT_W'(1)) begin
        h_d = diff;
      end
      if ((cnt_q >= CNT_W'(2)) && (diff != h_q)) begin
        uneven_d = 1'b1;
      end
      xprev_d = in_x_i;
      cnt_d   = cnt_q + CNT_W'(1);
    end
    job_o.n      = cnt_d;
    job_o.x0     = x0_d;
    job_o.xl     = xprev_d;
    job_o.h      = h_d;
    job_o.uneven = uneven_d;
    if (accept && in_last_i) begin
      job_push_o = 1'b1;
      cnt_d      = '0;
      uneven_d   = 1'b0;
      pending_d  = 1'b1;
    end
    if (done_i) begin
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      uneven_q  <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      uneven_q  <= uneven_d;
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q    <= x0_d;
    xprev_q <= xprev_d;
    h_q     <= h_d;
  end

  assign ld_o.we   = store;
  assign ld_o.addr = cnt_q[IDX_W-1:0];
  assign ld_o.x    = in_x_i;
  assign ld_o.y    = in_y_i;

endmodule

/* sv/nie_job_fifo.sv */
`timescale 1ns / 1ps

module nie_job_fifo import nie_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == (PW + 1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* sv/nie_back.sv */
`timescale 1ns / 1ps

module nie_back import nie_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_empty_i,
  input  job_t             job_i,
  output logic             job_pop_o,
  input  logic [31:0]      tgt_i,
  input  method_e          msel_i,
  output logic [IDX_W-1:0] d_raddr_o,
  input  logic [63:0]      d_rdata_i,
  output logic [IDX_W-1:0] x_raddr_o,
  input  logic [31:0]      x_rdata_i,
  output tbl_wr_t          tbl_wr_o,
  output mul_req_t         mul_req_o,
  input  mul_rsp_t         mul_rsp_i,
  output div_req_t         div_req_o,
  input  div_rsp_t         div_rsp_i,
  output logic             done_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      out_value_o,
  output logic [1:0]       out_status_o
);

  typedef enum logic [18:0] {
    ST_IDLE     = 19'h00001,
    ST_SETUP    = 19'h00002,
    ST_SINGLE   = 19'h00004,
    ST_VDIV     = 19'h00008,
    ST_TERM_A   = 19'h00010,
    ST_TERM_M   = 19'h00020,
    ST_TERM_W   = 19'h00040,
    ST_LVL_CUR  = 19'h00080,
    ST_LVL_A    = 19'h00100,
    ST_LVL_B    = 19'h00200,
    ST_LVL_C    = 19'h00400,
    ST_LVL_DIV  = 19'h00800,
    ST_LVL_NEXT = 19'h01000,
    ST_CF_A     = 19'h02000,
    ST_CF_B     = 19'h04000,
    ST_CF_MUL   = 19'h08000,
    ST_CF_DIV   = 19'h10000,
    ST_FINAL    = 19'h20000,
    ST_OUT      = 19'h40000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [31:0]      x0_q, x0_d, xl_q, xl_d, tgt_q, tgt_d, xa_q, xa_d;
  logic [32:0]      h_q, h_d;
  logic             uneven_q, uneven_d;
  method_e          msel_q, msel_d, mth_q, mth_d;
  logic [IDX_W-1:0] i_q, i_d, k_q, k_d;
  logic [63:0]      coef_q, coef_d, res_q, res_d, v_q, v_d;
  logic [63:0]      cur_q, cur_d, nxt_q, nxt_d;
  logic             sat_q, sat_d;
  logic [31:0]      val_q, val_d;
  status_e          stat_q, stat_d;
  logic             out_valid_q;
  logic [31:0]      out_value_q;
  status_e          out_status_q;
  logic             out_free, out_load;

  logic [32:0]      da, db, ad, bd, den33, tx33;
  method_e          m_auto, m_res;
  logic [63:0]      h64, vnum, iq;
  logic [CNT_W-1:0] term_idx, i_ext, k_ext, k_nxt, ki_nxt;
  sat_val_t         term_sum, lvl_dlt, cf_fwd, cf_bwd;
  logic             fits32;

  assign da     = {tgt_q[31], tgt_q} - {x0_q[31], x0_q};
  assign db     = {tgt_q[31], tgt_q} - {xl_q[31], xl_q};
  assign ad     = da[32] ? (33'd0 - da) : da;
  assign bd     = db[32] ? (33'd0 - db) : db;
  assign m_auto = uneven_q ? METH_DIV : ((ad > bd) ? METH_BWD : METH_FWD);
  assign m_res  = (msel_q == METH_AUTO) ? m_auto : msel_q;
  assign h64    = {{31{h_q[32]}}, h_q};
  assign vnum   = (m_res == METH_FWD) ? {{31{da[32]}}, da} : {{31{db[32]}}, db};
  assign i_ext  = CNT_W'(i_q);
  assign k_ext  = CNT_W'(k_q);
  assign k_nxt  = k_ext + CNT_W'(1);
  assign ki_nxt = k_ext + i_ext + CNT_W'(1);
  assign term_idx = n_q - i_ext - CNT_W'(1);
  assign iq     = 64'(i_q) << FRAC_BITS;
  assign den33  = {xa_q[31], xa_q} - {x_rdata_i[31], x_rdata_i};
  assign tx33   = {tgt_q[31], tgt_q} - {x_rdata_i[31], x_rdata_i};
  assign term_sum = sadd(res_q, mul_rsp_i.p);
  assign lvl_dlt  = ssub(nxt_q, cur_q);
  assign cf_fwd   = ssub(v_q, iq);
  assign cf_bwd   = sadd(v_q, iq);
  assign fits32   = (&res_q[63:31]) || !(|res_q[63:31]);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    x0_d      = x0_q;
    xl_d      = xl_q;
    tgt_d     = tgt_q;
    xa_d      = xa_q;
    h_d       = h_q;
    uneven_d  = uneven_q;
    msel_d    = msel_q;
    mth_d     = mth_q;
    i_d       = i_q;
    k_d       = k_q;
    coef_d    = coef_q;
    res_d     = res_q;
    v_d       = v_q;
    cur_d     = cur_q;
    nxt_d     = nxt_q;
    sat_d     = sat_q;
    val_d     = val_q;
    stat_d    = stat_q;
    job_pop_o = 1'b0;
    tbl_wr_o  = '0;
    mul_req_o = '0;
    div_req_o = '0;
    done_o    = 1'b0;
    out_load  = 1'b0;
    d_raddr_o = '0;
    x_raddr_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          n_d       = job_i.n;
          x0_d      = job_i.x0;
          xl_d      = job_i.xl;
          h_d       = job_i.h;
          uneven_d  = job_i.uneven;
          tgt_d     = tgt_i;
          msel_d    = msel_i;
          state_d   = ST_SETUP;
        end
      end
      ST_SETUP: begin
        coef_d = Q_ONE;
        res_d  = '0;
        sat_d  = 1'b0;
        i_d    = '0;
        mth_d  = m_res;
        if (n_q == CNT_W'(1)) begin
          state_d = ST_SINGLE;
        end else if (m_res != METH_DIV) begin
          if (h_q == '0) begin
            val_d   = '0;
            stat_d  = STAT_ZERO_DIV;
            state_d = ST_OUT;
          end else begin
            div_req_o.start = 1'b1;
            div_req_o.qmode = 1'b1;
            div_req_o.num   = vnum;
            div_req_o.den   = h64;
            state_d         = ST_VDIV;
          end
        end else begin
          state_d = ST_TERM_A;
        end
      end
      ST_SINGLE: begin
        val_d   = d_rdata_i[31:0];
        stat_d  = STAT_OK;
        state_d = ST_OUT;
      end
      ST_VDIV: begin
        if (div_rsp_i.done) begin
          v_d     = div_rsp_i.q;
          sat_d   = sat_q | div_rsp_i.sat;
          state_d = ST_TERM_A;
        end
      end
      ST_TERM_A: begin
        d_raddr_o = (mth_q == METH_BWD) ? term_idx[IDX_W-1:0] : '0;
        state_d   = ST_TERM_M;
      end
      ST_TERM_M: begin
        mul_req_o.start = 1'b1;
        mul_req_o.a     = coef_q;
        mul_req_o.b     = d_rdata_i;
        state_d         = ST_TERM_W;
      end
      ST_TERM_W: begin
        if (mul_rsp_i.done) begin
          res_d = term_sum.val;
          sat_d = sat_q | mul_rsp_i.sat | term_sum.sat;
          k_d   = '0;
          if ((i_ext + CNT_W'(1)) >= n_q) begin
            state_d = ST_FINAL;
          end else begin
            state_d = ST_LVL_CUR;
          end
        end
      end
      ST_LVL_CUR: begin
        cur_d   = d_rdata_i;
        state_d = ST_LVL_A;
      end
      ST_LVL_A: begin
        d_raddr_o = k_nxt[IDX_W-1:0];
        x_raddr_o = ki_nxt[IDX_W-1:0];
        state_d   = ST_LVL_B;
      end
      ST_LVL_B: begin
        nxt_d     = d_rdata_i;
        xa_d      = x_rdata_i;
        x_raddr_o = k_q;
        state_d   = ST_LVL_C;
      end
      ST_LVL_C: begin
        sat_d = sat_q | lvl_dlt.sat;
        if (mth_q == METH_DIV) begin
          if (den33 == '0) begin
            val_d   = '0;
            stat_d  = STAT_ZERO_DIV;
            state_d = ST_OUT;
          end else begin
            div_req_o.start = 1'b1;
            div_req_o.qmode = 1'b1;
            div_req_o.num   = lvl_dlt.val;
            div_req_o.den   = {{31{den33[32]}}, den33};
            state_d         = ST_LVL_DIV;
          end
        end else begin
          tbl_wr_o.we   = 1'b1;
          tbl_wr_o.addr = k_q;
          tbl_wr_o.data = lvl_dlt.val;
          state_d       = ST_LVL_NEXT;
        end
      end
      ST_LVL_DIV: begin
        if (div_rsp_i.done) begin
          tbl_wr_o.we   = 1'b1;
          tbl_wr_o.addr = k_q;
          tbl_wr_o.data = div_rsp_i.q;
          sat_d         = sat_q | div_rsp_i.sat;
          state_d       = ST_LVL_NEXT;
        end
      end
      ST_LVL_NEXT: begin
        cur_d = nxt_q;
        if ((k_ext + i_ext + CNT_W'(2)) == n_q) begin
          state_d = ST_CF_A;
        end else begin
          k_d     = k_q + IDX_W'(1);
          state_d = ST_LVL_A;
        end
      end
      ST_CF_A: begin
        x_raddr_o = i_q;
        state_d   = ST_CF_B;
      end
      ST_CF_B: begin
        mul_req_o.start = 1'b1;
        mul_req_o.a     = coef_q;
        case (mth_q)
          METH_FWD: begin
            mul_req_o.b = cf_fwd.val;
            sat_d       = sat_q | cf_fwd.sat;
          end
          METH_BWD: begin
            mul_req_o.b = cf_bwd.val;
            sat_d       = sat_q | cf_bwd.sat;
          end
          default: begin
            mul_req_o.b = {{31{tx33[32]}}, tx33};
          end
        endcase
        state_d = ST_CF_MUL;
      end
      ST_CF_MUL: begin
        if (mul_rsp_i.done) begin
          sat_d = sat_q | mul_rsp_i.sat;
          if (mth_q == METH_DIV) begin
            coef_d  = mul_rsp_i.p;
            i_d     = i_q + IDX_W'(1);
            state_d = ST_TERM_A;
          end else begin
            div_req_o.start = 1'b1;
            div_req_o.qmode = 1'b0;
            div_req_o.num   = mul_rsp_i.p;
            div_req_o.den   = 64'(i_q) + 64'd1;
            state_d         = ST_CF_DIV;
          end
        end
      end
      ST_CF_DIV: begin
        if (div_rsp_i.done) begin
          coef_d  = div_rsp_i.q;
          sat_d   = sat_q | div_rsp_i.sat;
          i_d     = i_q + IDX_W'(1);
          state_d = ST_TERM_A;
        end
      end
      ST_FINAL: begin
        if (fits32) begin
          val_d  = res_q[31:0];
          stat_d = sat_q ? STAT_SAT : STAT_OK;
        end else begin
          val_d  = res_q[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          stat_d = STAT_SAT;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          done_o   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    x0_q     <= x0_d;
    xl_q     <= xl_d;
    tgt_q    <= tgt_d;
    xa_q     <= xa_d;
    h_q      <= h_d;
    uneven_q <= uneven_d;
    msel_q   <= msel_d;
    mth_q    <= mth_d;
    i_q      <= i_d;
    k_q      <= k_d;
    coef_q   <= coef_d;
    res_q    <= res_d;
    v_q      <= v_d;
    cur_q    <= cur_d;
    nxt_q    <= nxt_d;
    sat_q    <= sat_d;
    val_q    <= val_d;
    stat_q   <= stat_d;
    if (out_load) begin
      out_value_q  <= val_q;
      out_status_q <= stat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule

/* sv/newton_interpolation_evaluator.sv */
`timescale 1ns / 1ps

// Channel   Direction  Contents
// s_axis    in         tdata: x_value, y_value; tlast: last_point
// m_axis    out        tdata: interp_value; tuser: status
// cfg       in         register 0 target_point, register 1 method_select
//
// A sample point is taken and written to the point memories in the same cycle.
// Evaluation of n points runs through a difference memory with one write and
// one read port, a shared bit-serial divider and a four-step multiplier.
// The input is held off from the last point of a run until its result is in
// the output register; the memories have no reset and need no clearing pass.

module newton_interpolation_evaluator import nie_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // x_value [31:0], y_value [63:32]
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // interp_value [31:0]
  output logic [1:0]           m_axis_tuser,   // status [1:0]
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  logic [31:0]      tgt_q;
  method_e          msel_q;
  load_wr_t         ld;
  tbl_wr_t          back_wr;
  job_t             job_in, job_out;
  logic             job_push, job_pop, job_full, job_empty, done;
  logic [IDX_W-1:0] d_raddr, x_raddr;
  logic [63:0]      d_rdata;
  logic [31:0]      x_rdata;
  mul_req_t         mul_req;
  mul_rsp_t         mul_rsp;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             d_we;
  logic [IDX_W-1:0] d_waddr;
  logic [63:0]      d_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q  <= '0;
      msel_q <= METH_AUTO;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TARGET: tgt_q  <= cfg_data_i;
        CFG_METHOD: msel_q <= method_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  nie_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_x_i      (s_axis_tdata[31:0]),
    .in_y_i      (s_axis_tdata[63:32]),
    .in_last_i   (s_axis_tlast),
    .fifo_full_i (job_full),
    .done_i      (done),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .ld_o        (ld)
  );

  nie_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  assign d_we    = back_wr.we | ld.we;
  assign d_waddr = back_wr.we ? back_wr.addr : ld.addr;
  assign d_wdata = back_wr.we ? back_wr.data : {{32{ld.y[31]}}, ld.y};

  nie_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (ld.we),
    .waddr_i (ld.addr),
    .wdata_i (ld.x),
    .raddr_i (x_raddr),
    .rdata_o (x_rdata)
  );

  nie_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_d_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  nie_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  nie_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  nie_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_empty_i  (job_empty),
    .job_i        (job_out),
    .job_pop_o    (job_pop),
    .tgt_i        (tgt_q),
    .msel_i       (msel_q),
    .d_raddr_o    (d_raddr),
    .d_rdata_i    (d_rdata),
    .x_raddr_o    (x_raddr),
    .x_rdata_i    (x_rdata),
    .tbl_wr_o     (back_wr),
    .mul_req_o    (mul_req),
    .mul_rsp_i    (mul_rsp),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .done_o       (done),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ld.we && back_wr.we))
    else $error("point load and table update collide on the difference memory");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(job_push && job_full))
    else $error("job pushed into a full queue");

  a_zero_div_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STAT_ZERO_DIV)) |-> (m_axis_tdata == '0))
    else $error("zero spacing result carries a nonzero value");

endmodule

/* verif/nie_checker.sv */
`timescale 1ns / 1ps

module nie_checker import nie_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,
  input  logic                 s_axis_tlast,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [31:0]          m_axis_tdata,
  input  logic [1:0]           m_axis_tuser,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [31:0] value;
    status_e     status;
  } answer_t;

  logic signed [63:0] xs [MAX_POINTS];
  logic signed [63:0] ds [MAX_POINTS];
  int                 stored;
  logic signed [31:0] target_q;
  method_e            method_q;
  logic               clamped;
  answer_t            answers [$];

  function automatic logic signed [63:0] to_signed(input logic [63:0] m, input logic neg,
                                                   input logic over);
    if (neg) begin
      if (over || m > INT64_MIN) begin
        clamped = 1'b1;
        return INT64_MIN;
      end
      return 64'd0 - m;
    end
    if (over || m[63]) begin
      clamped = 1'b1;
      return INT64_MAX;
    end
    return m;
  endfunction

  function automatic logic [63:0] magn(input logic signed [63:0] a);
    return a < 0 ? 64'd0 - a : a;
  endfunction

  function automatic logic signed [63:0] add_s(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s > $signed(65'(INT64_MAX))) begin
      clamped = 1'b1;
      return INT64_MAX;
    end
    if (s < -$signed(66'h0_8000_0000_0000_0000)) begin
      clamped = 1'b1;
      return INT64_MIN;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_s(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = a - b;
    if (s > $signed(65'(INT64_MAX))) begin
      clamped = 1'b1;
      return INT64_MAX;
    end
    if (s < -$signed(66'h0_8000_0000_0000_0000)) begin
      clamped = 1'b1;
      return INT64_MIN;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] mul_q(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [127:0] p;
    p = {64'd0, magn(a)} * {64'd0, magn(b)};
    return to_signed(p[FRAC_BITS +: 64], (a < 0) != (b < 0), |p[127:64+FRAC_BITS]);
  endfunction

  function automatic logic signed [63:0] div_q(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [63:0] ma, d;
    logic [79:0] q;
    ma = magn(a);
    d  = magn(b);
    if ((ma >> (64 - FRAC_BITS)) >= d) return to_signed(64'd0, (a < 0) != (b < 0), 1'b1);
    q = {ma, 16'h0} / {16'h0, d};
    return to_signed(q[63:0], (a < 0) != (b < 0), 1'b0);
  endfunction

  function automatic answer_t interpolate(input int n);
    logic signed [63:0] one, tgt, coef, acc, v, h, da, db, term, dlt, den;
    method_e            m;
    answer_t            r;
    clamped  = 1'b0;
    r.value  = '0;
    r.status = STAT_OK;
    one  = 64'sd1 <<< FRAC_BITS;
    tgt  = target_q;
    m    = method_q;
    coef = one;
    acc  = 0;
    v    = 0;
    if (n == 0) return r;
    if (n == 1) begin
      r.value = ds[0][31:0];
      return r;
    end
    h = xs[1] - xs[0];
    if (m == METH_AUTO) begin
      m = METH_FWD;
      for (int i = 2; i < n; i++) if (xs[i] - xs[i-1] != h) m = METH_DIV;
      if (m == METH_FWD) begin
        da = tgt - xs[0];
        db = tgt - xs[n-1];
        if (magn(da) > magn(db)) m = METH_BWD;
      end
    end
    if (m != METH_DIV) begin
      if (h == 0) begin
        r.status = STAT_ZERO_DIV;
        return r;
      end
      v = div_q(tgt - xs[m == METH_FWD ? 0 : n-1], h);
    end
    for (int i = 0; i < n; i++) begin
      term = (m == METH_BWD) ? ds[n-1-i] : ds[0];
      acc  = add_s(acc, mul_q(coef, term));
      if (i + 1 >= n) break;
      for (int k = 0; k + 1 + i < n; k++) begin
        dlt = sub_s(ds[k+1], ds[k]);
        if (m == METH_DIV) begin
          den = xs[k+i+1] - xs[k];
          if (den == 0) begin
            r.value  = '0;
            r.status = STAT_ZERO_DIV;
            return r;
          end
          dlt = div_q(dlt, den);
        end
        ds[k] = dlt;
      end
      if (m == METH_FWD)
        coef = mul_q(coef, sub_s(v, 64'(i) <<< FRAC_BITS)) / (i + 1);
      else if (m == METH_BWD)
        coef = mul_q(coef, add_s(v, 64'(i) <<< FRAC_BITS)) / (i + 1);
      else
        coef = mul_q(coef, tgt - xs[i]);
    end
    if (acc > 64'sh7FFF_FFFF) begin
      acc = 64'sh7FFF_FFFF;
      clamped = 1'b1;
    end
    if (acc < -64'sh8000_0000) begin
      acc = -64'sh8000_0000;
      clamped = 1'b1;
    end
    r.value  = acc[31:0];
    r.status = clamped ? STAT_SAT : STAT_OK;
    return r;
  endfunction

  assign pending_o = answers.size();

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    int      errs;
    errs = 0;
    if (!rst_ni) begin
      stored        = 0;
      target_q     <= '0;
      method_q     <= METH_AUTO;
      fail_count_o <= 0;
      answers.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_TARGET) target_q <= cfg_data_i;
        else method_q <= method_e'(cfg_data_i[1:0]);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (stored < MAX_POINTS) begin
          xs[stored] = $signed(s_axis_tdata[31:0]);
          ds[stored] = $signed(s_axis_tdata[63:32]);
          stored = stored + 1;
        end
        if (s_axis_tlast) begin
          answers = {answers, interpolate(stored)};
          stored = 0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.value  = m_axis_tdata;
        got.status = status_e'(m_axis_tuser);
        if (answers.size() == 0) begin
          $error("unexpected result: interp_value %0d status %0d",
                 $signed(got.value), got.status);
          errs++;
        end else begin
          want = answers.pop_front();
          if (got.value !== want.value) begin
            $error("interp_value: expected %0d, got %0d",
                   $signed(want.value), $signed(got.value));
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import nie_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_TARGET;
  logic [31:0]          cfg_data_i = '0;
  int                   fail_count;
  int                   pending;
  int                   sent;
  int                   quiet_cycles;
  logic                 calm;

  always #4 clk_i = ~clk_i;

  newton_interpolation_evaluator dut (.*);

  nie_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  assign calm = (sent > 700) && (sent < 950);

  always @(posedge clk_i) m_axis_tready <= calm || ($urandom_range(0, 99) >= 17);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 300000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int rnd_s(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic last);
    while (!calm && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic setup(input logic [31:0] tgt, input method_e m);
    settle();
    write_reg(CFG_TARGET, tgt);
    write_reg(CFG_METHOD, m);
  endtask

  task automatic even_run(input int n, input int x0, input int h, input int jitter,
                          input int yspan);
    for (int i = 0; i < n; i++)
      send_point(x0 + i * h + (i == n / 2 ? jitter : 0), rnd_s(yspan), i == n - 1);
  endtask

  initial begin
    int      n, x0, h;
    method_e m;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single point under each method, then field extremes.
    for (int k = 0; k < 4; k++) begin
      setup(32'h0001_8000, method_e'(k));
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    end
    setup(32'h8000_0000, METH_FWD);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    // Zero spacing for forward, backward and divided differences.
    setup(32'h0002_0000, METH_FWD);
    even_run(2, 32'h0001_0000, 0, 0, 1 << 18);
    setup(32'h0002_0000, METH_BWD);
    even_run(3, 32'h0001_0000, 0, 0, 1 << 18);
    setup(32'h0002_0000, METH_DIV);
    even_run(3, 32'h0001_0000, 0, 32'h0001_0000, 1 << 18);
    // Automatic: even spacing near the first point, and uneven spacing near the last.
    setup(32'h0000_8000, METH_AUTO);
    even_run(4, 0, 32'h0001_0000, 0, 1 << 20);
    setup(32'h7FFF_FFFF, METH_AUTO);
    even_run(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_4000, 32'h7FFF_FFFF);
    // Saturation through huge ordinates.
    setup(32'h7FFF_FFFF, METH_FWD);
    send_point(0, 32'h8000_0000, 1'b0);
    send_point(32'h0000_0001, 32'h7FFF_FFFF, 1'b1);

    while (sent < 1550) begin
      if ($urandom_range(0, 99) < 30 || sent < 40) begin
        m = method_e'($urandom_range(0, 3));
        setup($urandom_range(0, 9) == 0 ? $urandom() : rnd_s(1 << 20), m);
      end
      n = ($urandom_range(0, 99) < 3) ? $urandom_range(9, 36) : $urandom_range(1, 8);
      if ($urandom_range(0, 99) < 80) begin
        x0 = rnd_s(1 << 19);
        h  = rnd_s(1 << 17);
        even_run(n, x0, h, ($urandom_range(0, 2) == 0) ? rnd_s(1 << 14) : 0,
                 ($urandom_range(0, 9) == 0) ? (1 << 30) : (1 << 20));
      end else begin
        for (int i = 0; i < n; i++) send_point($urandom(), $urandom(), i == n - 1);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
